[rtl/frpp_pkg.sv]
// ----------------------------------------------------------------------------
// frpp_pkg: shared types and codes for the float pixel packer
// Item structs, output format codes and configuration register indexes.
// ----------------------------------------------------------------------------
package frpp_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_HAS_ALPHA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FORMAT = 2'd1;

	// Largest channel multiplier: 255 * 65536
	localparam int unsigned MUL_W = 24;

	typedef enum logic [2:0] {
		FMT_RGB8     = 3'd0,
		FMT_BGR565   = 3'd1,
		FMT_RGB565   = 3'd2,
		FMT_BGR888   = 3'd3,
		FMT_RGB888   = 3'd4,
		FMT_RGBA8888 = 3'd5,
		FMT_ARGB8888 = 3'd6,
		FMT_BGR8888  = 3'd7
	} fmt_t;

	// Per-item control carried down the pipeline
	typedef struct packed {
		fmt_t fmt;
		logic pa;
	} ctl_t;

	typedef struct packed {
		logic [31:0] red_float;
		logic [31:0] green_float;
		logic [31:0] blue_float;
		logic [31:0] alpha_float;
	} in_t;

	typedef struct packed {
		logic [31:0] pixel_bytes;
		logic [2:0]  byte_count;
		logic [3:0]  byte_mask;
	} out_t;

endpackage

[rtl/frpp_chan_fix.sv]
// ----------------------------------------------------------------------------
// frpp_chan_fix: IEEE single to unsigned fixed point in [0,1]
// NaN and negatives give 0, values of one or more give exactly 1.0,
// everything else is truncated to FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module frpp_chan_fix #(
	parameter int unsigned FRAC_BITS = 24
) (
	input  logic [31:0]        bits,
	output logic [FRAC_BITS:0] fix
);
	localparam int unsigned WIDE_W = 24 + FRAC_BITS;

	logic [7:0]        exp_f;
	logic [22:0]       man_f;
	logic [23:0]       mant;
	logic [7:0]        shamt;
	logic [WIDE_W-1:0] wide;

	assign exp_f = bits[30:23];
	assign man_f = bits[22:0];

	// Denormals use exponent one without the hidden bit
	assign mant  = (exp_f == 8'd0) ? {1'b0, man_f} : {1'b1, man_f};
	assign shamt = (exp_f == 8'd0) ? 8'd149 : (8'd150 - exp_f);
	assign wide  = {mant, {FRAC_BITS{1'b0}}} >> shamt;

	always_comb begin
		if (exp_f == 8'hff && man_f != 23'd0) begin
			fix = '0;
		end else if (bits[31]) begin
			fix = '0;
		end else if (exp_f >= 8'd127) begin
			fix = {1'b1, {FRAC_BITS{1'b0}}};
		end else begin
			fix = {1'b0, wide[FRAC_BITS-1:0]};
		end
	end

endmodule

[rtl/frpp_pack.sv]
// ----------------------------------------------------------------------------
// frpp_pack: field selection for the packed output formats
// Takes scaled channel values and places them per format and alpha mode.
// ----------------------------------------------------------------------------
module frpp_pack (
	input  frpp_pkg::ctl_t          ctl,
	input  logic [frpp_pkg::MUL_W-1:0] cr,
	input  logic [frpp_pkg::MUL_W-1:0] cg,
	input  logic [frpp_pkg::MUL_W-1:0] cb,
	input  logic [7:0]              a8,
	output frpp_pkg::out_t          px
);
	import frpp_pkg::*;

	logic [7:0] ca;

	// Alpha byte is opaque for RGB input
	assign ca = ctl.pa ? a8 : 8'hff;

	always_comb begin
		px = '0;
		case (ctl.fmt)
			FMT_RGB8: begin
				if (ctl.pa) begin
					px.pixel_bytes[7:0] = {cr[23:22], cg[23:21], cb[23:21]};
				end else begin
					px.pixel_bytes[7:0] = {cr[1:0], 1'b0, cg[2:0], cb[1:0]};
				end
				px.byte_count = 3'd1;
				px.byte_mask  = 4'h1;
			end
			FMT_BGR565: begin
				if (ctl.pa) begin
					px.pixel_bytes[15:0] = {cb[23:19], cg[23:18], cr[23:19]};
				end else begin
					px.pixel_bytes[15:0] = {cb[4:0], cg[5:0], cr[4:0]};
				end
				px.byte_count = 3'd2;
				px.byte_mask  = 4'h3;
			end
			FMT_RGB565: begin
				if (ctl.pa) begin
					px.pixel_bytes[15:0] = {cr[23:19], cg[23:18], cb[23:19]};
				end else begin
					px.pixel_bytes[15:0] = {cr[4:0], cg[5:0], cb[4:0]};
				end
				px.byte_count = 3'd2;
				px.byte_mask  = 4'h3;
			end
			FMT_RGB888: begin
				px.pixel_bytes = {8'h00, cb[7:0], cg[7:0], cr[7:0]};
				px.byte_count  = 3'd3;
				px.byte_mask   = 4'h7;
			end
			FMT_BGR888: begin
				px.pixel_bytes = {8'h00, cr[7:0], cg[7:0], cb[7:0]};
				px.byte_count  = 3'd3;
				px.byte_mask   = 4'h7;
			end
			FMT_BGR8888: begin
				// Fourth byte is skipped, not written
				px.pixel_bytes = {8'h00, cr[7:0], cg[7:0], cb[7:0]};
				px.byte_count  = 3'd4;
				px.byte_mask   = 4'h7;
			end
			FMT_RGBA8888: begin
				px.pixel_bytes = {ca, cb[7:0], cg[7:0], cr[7:0]};
				px.byte_count  = 3'd4;
				px.byte_mask   = 4'hf;
			end
			FMT_ARGB8888: begin
				px.pixel_bytes = {cb[7:0], cg[7:0], cr[7:0], ca};
				px.byte_count  = 3'd4;
				px.byte_mask   = 4'hf;
			end
			default: begin
				px = '0;
			end
		endcase
	end

endmodule

[rtl/float_rgba_to_packed_pixel.sv]
// ----------------------------------------------------------------------------
// float_rgba_to_packed_pixel: float RGBA pixel to packed integer pixel
// Four-stage pipeline: float to fixed, multiplier select, channel scale, pack.
// ----------------------------------------------------------------------------
// One pixel of four IEEE single channels enters per clock unless float_stall
// is high, and leaves packed as RGB8, 565, 888 or 8888 bytes; the pipeline
// sustains one pixel per clock with no stalls downstream. The stages are:
// stage 1 turns each channel into fixed point with FRAC_BITS fraction bits,
// stage 2 forms the alpha factors and per-channel multipliers, stage 3 holds
// the three scaled channels, stage 4 is the output register. Empty stages
// close up while the output is stalled. Configuration (cfg_index 0: RGBA input
// with premultiply, 1: output format) is captured with each pixel on entry and
// should be written only while no pixel is in flight; cfg_ready is always high.
module float_rgba_to_packed_pixel #(
	parameter int unsigned FRAC_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [frpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frpp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           float_valid,
	output logic                           float_stall,
	input  frpp_pkg::in_t                  float_px,
	output logic                           packed_valid,
	input  logic                           packed_stall,
	output frpp_pkg::out_t                 packed_px
);
	import frpp_pkg::*;

	localparam int unsigned FW = FRAC_BITS + 1;

	logic input_has_alpha_q;
	fmt_t output_format_q;

	logic adv1, adv2, adv3, adv4;

	logic [FW-1:0] r_fix, g_fix, b_fix, a_fix;

	logic          v_s1, v_s2, v_s3, v_s4;
	ctl_t          ctl_s1, ctl_s2, ctl_s3;
	logic [FW-1:0] r_s1, g_s1, b_s1, a_s1;
	logic [FW-1:0] r_s2, g_s2, b_s2;
	logic [MUL_W-1:0] mr_s2, mg_s2, mb_s2;
	logic [7:0]    a8_s2, a8_s3;
	logic [MUL_W-1:0] cr_s3, cg_s3, cb_s3;
	out_t          px_s4;

	logic [FW+7:0]   a8_prod;
	logic [FW+15:0]  a16_wide;
	logic [16:0]     a16;
	logic [MUL_W:0]  a16x255;
	logic [7:0]      a8;
	logic [MUL_W-1:0] mr, mg, mb;
	logic [FW+MUL_W-1:0] r_prod, g_prod, b_prod;
	out_t            px;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_has_alpha_q <= 1'b0;
			output_format_q   <= FMT_RGB8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INPUT_HAS_ALPHA: input_has_alpha_q <= cfg_data[0];
				CFG_OUTPUT_FORMAT:   output_format_q   <= fmt_t'(cfg_data[2:0]);
				default: ;
			endcase
		end
	end

	// Stage advance: a stage loads when empty or when its successor loads
	assign adv4 = !v_s4 || !packed_stall;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign float_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= float_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Stage 1: float to fixed point
	frpp_chan_fix #(.FRAC_BITS(FRAC_BITS)) u_fix_r (.bits(float_px.red_float),   .fix(r_fix));
	frpp_chan_fix #(.FRAC_BITS(FRAC_BITS)) u_fix_g (.bits(float_px.green_float), .fix(g_fix));
	frpp_chan_fix #(.FRAC_BITS(FRAC_BITS)) u_fix_b (.bits(float_px.blue_float),  .fix(b_fix));
	frpp_chan_fix #(.FRAC_BITS(FRAC_BITS)) u_fix_a (.bits(float_px.alpha_float), .fix(a_fix));

	always_ff @(posedge clk) begin
		if (adv1 && float_valid) begin
			r_s1       <= r_fix;
			g_s1       <= g_fix;
			b_s1       <= b_fix;
			a_s1       <= a_fix;
			ctl_s1.fmt <= output_format_q;
			ctl_s1.pa  <= input_has_alpha_q;
		end
	end

	// Stage 2: alpha factors and per-channel multipliers
	assign a8_prod  = {8'd0, a_s1} * {{FW{1'b0}}, 8'hff};
	assign a8       = a8_prod[FRAC_BITS+7:FRAC_BITS];
	assign a16_wide = {a_s1, 16'd0} >> FRAC_BITS;
	assign a16      = a16_wide[16:0];
	assign a16x255  = {a16, 8'd0} - {8'd0, a16};

	always_comb begin
		mr = MUL_W'(8'hff);
		mg = MUL_W'(8'hff);
		mb = MUL_W'(8'hff);
		case (ctl_s1.fmt)
			FMT_RGB8: begin
				if (ctl_s1.pa) begin
					mr = a16x255[MUL_W-1:0];
					mg = a16x255[MUL_W-1:0];
					mb = a16x255[MUL_W-1:0];
				end else begin
					mr = MUL_W'(2'h3);
					mg = MUL_W'(3'h7);
					mb = MUL_W'(2'h3);
				end
			end
			FMT_BGR565, FMT_RGB565: begin
				if (ctl_s1.pa) begin
					mr = a16x255[MUL_W-1:0];
					mg = a16x255[MUL_W-1:0];
					mb = a16x255[MUL_W-1:0];
				end else begin
					mr = MUL_W'(5'h1f);
					mg = MUL_W'(6'h3f);
					mb = MUL_W'(5'h1f);
				end
			end
			FMT_BGR888, FMT_RGB888, FMT_BGR8888: begin
				if (ctl_s1.pa) begin
					mr = MUL_W'(a8);
					mg = MUL_W'(a8);
					mb = MUL_W'(a8);
				end
			end
			default: begin
				// 8888 with alpha byte: color stays straight
				mr = MUL_W'(8'hff);
				mg = MUL_W'(8'hff);
				mb = MUL_W'(8'hff);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			r_s2   <= r_s1;
			g_s2   <= g_s1;
			b_s2   <= b_s1;
			mr_s2  <= mr;
			mg_s2  <= mg;
			mb_s2  <= mb;
			a8_s2  <= a8;
			ctl_s2 <= ctl_s1;
		end
	end

	// Stage 3: scale each channel and drop the fraction
	assign r_prod = {{MUL_W{1'b0}}, r_s2} * {{FW{1'b0}}, mr_s2};
	assign g_prod = {{MUL_W{1'b0}}, g_s2} * {{FW{1'b0}}, mg_s2};
	assign b_prod = {{MUL_W{1'b0}}, b_s2} * {{FW{1'b0}}, mb_s2};

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			cr_s3  <= r_prod[FRAC_BITS+MUL_W-1:FRAC_BITS];
			cg_s3  <= g_prod[FRAC_BITS+MUL_W-1:FRAC_BITS];
			cb_s3  <= b_prod[FRAC_BITS+MUL_W-1:FRAC_BITS];
			a8_s3  <= a8_s2;
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 4: pack into the output register
	frpp_pack u_pack (
		.ctl (ctl_s3),
		.cr  (cr_s3),
		.cg  (cg_s3),
		.cb  (cb_s3),
		.a8  (a8_s3),
		.px  (px)
	);

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			px_s4 <= px;
		end
	end

	assign packed_valid = v_s4;
	assign packed_px    = px_s4;

endmodule
